### design/mfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mfd_pkg - shared types and constants of the marker frame deframer
// Marker bytes, status codes, queue sizes and the records that pass
// between the front end, the command queue and the drain engine.
// ---------------------------------------------------------------------------
package mfd_pkg;

  localparam int MAX_BODY_DEF = 64;

  localparam logic [7:0] START_BYTE = 8'd255;
  localparam logic [7:0] END_BYTE   = 8'd254;
  localparam logic [7:0] SUM_MOD    = 8'd253;

  localparam logic [1:0] ST_PAYLOAD  = 2'd0;
  localparam logic [1:0] ST_EMPTY_OK = 2'd1;
  localparam logic [1:0] ST_CSUM_ERR = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Payload lengths never exceed MAX_BODY - 1, so eight bits suffice while MAX_BODY <= 256.
  localparam int LEN_W = 8;

  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]       status;
    logic             bank;
    logic [LEN_W-1:0] plen;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } res_t;

endpackage
`default_nettype wire

### design/mfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mfd_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module mfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

### design/mfd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mfd_fifo - small register FIFO
// Used for the command queue and the result queue; reports its fill level.
// ---------------------------------------------------------------------------
module mfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           din,
  output logic                            full,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           dout,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

### design/mfd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mfd_front - frame hunter and body collector
// Tracks the frame, stores body bytes into the current RAM bank, keeps the
// running checksum and posts one command per finished frame.
// ---------------------------------------------------------------------------
module mfd_front #(
  parameter int MAX_BODY = mfd_pkg::MAX_BODY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  input  wire logic [7:0]                      rx_byte,
  output logic                                 full,
  input  wire logic                            cmdq_full,
  output logic                                 cmd_push,
  output mfd_pkg::cmd_t                        cmd,
  output logic                                 ram_we,
  output logic      [$clog2(MAX_BODY):0]       ram_waddr,
  output logic      [7:0]                      ram_wdata,
  input  wire logic                            bank_release
);

  localparam int IW = $clog2(MAX_BODY);
  localparam int CW = $clog2(MAX_BODY + 1);

  logic          in_frame_r, in_frame_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    latest_r, latest_nxt;
  logic          bank_r, bank_nxt;
  logic [1:0]    pend_r, pend_nxt;
  logic          commit;
  logic          accept;
  logic [7:0]    lat_red;
  logic [8:0]    sum_wide;

  // Command queue full, or both banks busy until the drain hands one back.
  assign full   = cmdq_full || (pend_r == 2'd2);
  assign accept = push && !full;

  assign ram_waddr = {bank_r, count_r[IW-1:0]};
  assign ram_wdata = rx_byte;

  always_comb begin
    lat_red  = (latest_r >= mfd_pkg::SUM_MOD) ? latest_r - mfd_pkg::SUM_MOD : latest_r;
    sum_wide = {1'b0, sum_r} + {1'b0, lat_red};
    if (sum_wide >= {1'b0, mfd_pkg::SUM_MOD}) begin
      sum_wide = sum_wide - {1'b0, mfd_pkg::SUM_MOD};
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    latest_nxt   = latest_r;
    bank_nxt     = bank_r;
    commit       = 1'b0;
    cmd_push     = 1'b0;
    cmd.status   = mfd_pkg::ST_CSUM_ERR;
    cmd.bank     = bank_r;
    cmd.plen     = mfd_pkg::LEN_W'(count_r) - 1'b1;
    ram_we       = 1'b0;
    if (accept) begin
      if (!in_frame_r) begin
        if (rx_byte == mfd_pkg::START_BYTE) begin
          in_frame_nxt = 1'b1;
          count_nxt    = '0;
          sum_nxt      = '0;
          latest_nxt   = '0;
        end
      end else if (rx_byte != mfd_pkg::END_BYTE) begin
        if (count_r >= CW'(MAX_BODY)) begin
          cmd_push     = 1'b1;
          cmd.status   = mfd_pkg::ST_OVERFLOW;
          in_frame_nxt = 1'b0;
          count_nxt    = '0;
          sum_nxt      = '0;
          latest_nxt   = '0;
        end else begin
          ram_we     = 1'b1;
          if (count_r != '0) begin
            sum_nxt = sum_wide[7:0];
          end
          latest_nxt = rx_byte;
          count_nxt  = count_r + 1'b1;
        end
      end else begin
        cmd_push = 1'b1;
        if (count_r == '0 || latest_r != sum_r) begin
          cmd.status = mfd_pkg::ST_CSUM_ERR;
        end else if (count_r == CW'(1)) begin
          cmd.status = mfd_pkg::ST_EMPTY_OK;
        end else begin
          cmd.status = mfd_pkg::ST_PAYLOAD;
          commit     = 1'b1;
          bank_nxt   = ~bank_r;
        end
        in_frame_nxt = 1'b0;
        count_nxt    = '0;
        sum_nxt      = '0;
        latest_nxt   = '0;
      end
    end
  end

  always_comb begin
    case ({commit, bank_release})
      2'b10:   pend_nxt = pend_r + 1'b1;
      2'b01:   pend_nxt = pend_r - 1'b1;
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      sum_r      <= '0;
      latest_r   <= '0;
      bank_r     <= 1'b0;
      pend_r     <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      latest_r   <= latest_nxt;
      bank_r     <= bank_nxt;
      pend_r     <= pend_nxt;
    end
  end

  a_cmd_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmdq_full)
    else $error("command posted into a full queue");

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more banks pending than exist");

  a_release_owned: assert property (@(posedge clk) disable iff (!rst_n)
    bank_release |-> pend_r != 2'd0)
    else $error("bank released while none pending");

endmodule
`default_nettype wire

### design/mfd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mfd_back - drain engine
// Takes commands in order, turns status commands into one result and
// streams a payload bank out of the RAM into the result queue.
// ---------------------------------------------------------------------------
module mfd_back #(
  parameter int MAX_BODY = mfd_pkg::MAX_BODY_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire mfd_pkg::cmd_t                  cmd,
  input  wire logic                           cmdq_empty,
  output logic                                cmdq_pop,
  output logic      [$clog2(MAX_BODY):0]      ram_raddr,
  input  wire logic [7:0]                     ram_rdata,
  output logic                                outq_push,
  output mfd_pkg::res_t                       outq_din,
  input  wire logic                           outq_full,
  input  wire logic [mfd_pkg::OUTQ_CNT_W-1:0] outq_count,
  output logic                                bank_release
);

  localparam int IW = $clog2(MAX_BODY);
  localparam int LW = mfd_pkg::LEN_W;
  localparam int OW = mfd_pkg::OUTQ_CNT_W;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic          state_r, state_nxt;
  logic          bank_r, bank_nxt;
  logic [LW-1:0] plen_r, plen_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic [OW:0]   occ;
  logic          credit;

  // Room for one more beat, counting a read still in flight.
  assign occ       = {1'b0, outq_count} + {{OW{1'b0}}, rd_vld_r};
  assign credit    = occ < (OW + 1)'(mfd_pkg::OUTQ_DEPTH);
  assign ram_raddr = {bank_r, idx_r[IW-1:0]};

  always_comb begin
    state_nxt       = state_r;
    bank_nxt        = bank_r;
    plen_nxt        = plen_r;
    idx_nxt         = idx_r;
    rd_vld_nxt      = 1'b0;
    rd_last_nxt     = rd_last_r;
    cmdq_pop        = 1'b0;
    bank_release    = 1'b0;
    outq_push       = rd_vld_r;
    outq_din.data   = ram_rdata;
    outq_din.last   = rd_last_r;
    outq_din.status = mfd_pkg::ST_PAYLOAD;
    case (state_r)
      S_IDLE: begin
        if (!cmdq_empty && credit && !rd_vld_r) begin
          cmdq_pop = 1'b1;
          if (cmd.status == mfd_pkg::ST_PAYLOAD) begin
            bank_nxt  = cmd.bank;
            plen_nxt  = cmd.plen;
            idx_nxt   = '0;
            state_nxt = S_DRAIN;
          end else begin
            outq_push       = 1'b1;
            outq_din.data   = '0;
            outq_din.last   = 1'b1;
            outq_din.status = cmd.status;
          end
        end
      end
      S_DRAIN: begin
        if (credit) begin
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (idx_r == plen_r - 1'b1);
          idx_nxt     = idx_r + 1'b1;
          if (idx_r == plen_r - 1'b1) begin
            bank_release = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r    <= bank_nxt;
    plen_r    <= plen_nxt;
    idx_r     <= idx_nxt;
    rd_last_r <= rd_last_nxt;
  end

  a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
    outq_push |-> !outq_full)
    else $error("result pushed into a full queue");

  a_drain_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (plen_r != '0) && (idx_r < plen_r))
    else $error("drain index out of range");

  a_release_ends: assert property (@(posedge clk) disable iff (!rst_n)
    bank_release |=> (state_r == S_IDLE) && rd_vld_r && rd_last_r)
    else $error("bank released without its final read");

endmodule
`default_nettype wire

### design/marker_frame_deframer_mod253_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// marker_frame_deframer_mod253_top - marker framed byte deframer
// Hunts for a start byte, collects the frame body, checks a sum-mod-253
// checksum on the end byte and delivers the payload or a status beat.
// ---------------------------------------------------------------------------
//
//   Channel  Ports                              Direction  Beat
//   input    push, full, in_rx_byte             in         one received byte
//   result   empty, pop, out_byte, out_last,    out        one payload byte or
//            out_status                                    one status word
//
// Every accepted byte is handled in the cycle it arrives. With the drain
// engine idle, a status beat reaches the result ports through the command
// and result queues, and the first payload beat also through the drain state
// and the RAM read register; the payload then streams at one beat per cycle
// while the result queue has room, limited by the body RAM's single read port.
// Reset is synchronous and active low; it returns to hunting and empties
// both queues. Body RAM contents are not cleared and need not be.
// full rises while the command queue is full or while both body banks
// hold frames that are still draining; a stalled result side backs up the
// result queue, then the drain, then the command queue.
//
// Structure: the front end writes body bytes into one half of a two-bank
// RAM while the drain engine reads frames out of the other half. A short
// command queue carries one entry per finished frame between the two.
module marker_frame_deframer_mod253_top #(
  parameter int MAX_BODY = mfd_pkg::MAX_BODY_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_rx_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic      [7:0] out_byte,
  output logic            out_last,
  output logic      [1:0] out_status
);

  localparam int AW     = $clog2(MAX_BODY) + 1;
  localparam int CMD_W  = $bits(mfd_pkg::cmd_t);
  localparam int RES_W  = $bits(mfd_pkg::res_t);

  mfd_pkg::cmd_t cmd_in, cmd_out;
  mfd_pkg::res_t res_in, res_out;
  logic          cmd_push, cmd_pop, cmdq_full, cmdq_empty;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          outq_push, outq_full;
  logic [mfd_pkg::OUTQ_CNT_W-1:0] outq_count;
  logic [$clog2(mfd_pkg::CMDQ_DEPTH + 1)-1:0] cmdq_count;
  logic          bank_release;

  // Front end: frame tracking, checksum, body storage.
  mfd_front #(
    .MAX_BODY (MAX_BODY)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .rx_byte      (in_rx_byte),
    .full         (full),
    .cmdq_full    (cmdq_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .bank_release (bank_release)
  );

  // Two banks of MAX_BODY-rounded-up entries, selected by the top address bit.
  mfd_ram #(
    .WIDTH (8),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Command queue: one entry per finished or aborted frame, in order.
  mfd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (mfd_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmdq_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmdq_empty),
    .count (cmdq_count)
  );

  // Drain engine: turns commands into result beats.
  mfd_back #(
    .MAX_BODY (MAX_BODY)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd_out),
    .cmdq_empty   (cmdq_empty),
    .cmdq_pop     (cmd_pop),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .outq_push    (outq_push),
    .outq_din     (res_in),
    .outq_full    (outq_full),
    .outq_count   (outq_count),
    .bank_release (bank_release)
  );

  // Result queue: decouples the drain from the consumer's pop pattern.
  mfd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (mfd_pkg::OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (outq_push),
    .din   (res_in),
    .full  (outq_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty),
    .count (outq_count)
  );

  assign out_byte   = res_out.data;
  assign out_last   = res_out.last;
  assign out_status = res_out.status;

  // The command queue never holds more entries than it has slots.
  a_cmdq_level: assert property (@(posedge clk) disable iff (!rst_n)
    cmdq_count <= ($clog2(mfd_pkg::CMDQ_DEPTH + 1))'(mfd_pkg::CMDQ_DEPTH))
    else $error("command queue level out of range");

endmodule
`default_nettype wire

### test/tb_marker_frame_deframer_mod253_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_marker_frame_deframer_mod253_top - self-checking bench for the deframer
// Drives received bytes into the push side and checks every beat popped from
// the result side against a behavioural model of the frame hunter and the
// sum-mod-253 check. A short directed table comes first, then random framed
// traffic under several idling mixes and one long result-side hold-off.
// ---------------------------------------------------------------------------
module tb_marker_frame_deframer_mod253_top;

  localparam int BODY_SLOTS      = mfd_pkg::MAX_BODY_DEF;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PHASE_BYTES     = 16;
  localparam int N_DIRECTED      = 24;

  // Shapes of frame that the random traffic is built from.
  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_HIGH_SUM,
    FR_NO_SUM,
    FR_OVERFLOW
  } frame_kind_t;

  // One row of the directed table. Where typed is set, the row carries its
  // own expectation (has_result says whether a beat is due at all) and the
  // model only keeps its state in step; elsewhere the model decides.
  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    logic          has_result;
    mfd_pkg::res_t want;
  } row_t;

  localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // Hunting: anything but the start byte is thrown away.
    '{8'h00,               1'b1, 1'b0, '0},
    '{mfd_pkg::END_BYTE,   1'b1, 1'b0, '0},
    // Start then end at once: no checksum byte at all.
    '{mfd_pkg::START_BYTE, 1'b0, 1'b0, '0},
    '{mfd_pkg::END_BYTE,   1'b1, 1'b1, '{8'd0, 1'b1, mfd_pkg::ST_CSUM_ERR}},
    // Zero-length payload with a zero checksum.
    '{mfd_pkg::START_BYTE, 1'b0, 1'b0, '0},
    '{8'h00,               1'b0, 1'b0, '0},
    '{mfd_pkg::END_BYTE,   1'b1, 1'b1, '{8'd0, 1'b1, mfd_pkg::ST_EMPTY_OK}},
    // A start byte inside a frame is plain data; 255 mod 253 is 2.
    '{mfd_pkg::START_BYTE, 1'b0, 1'b0, '0},
    '{mfd_pkg::START_BYTE, 1'b0, 1'b0, '0},
    '{8'h02,               1'b0, 1'b0, '0},
    '{mfd_pkg::END_BYTE,   1'b1, 1'b1, '{8'hFF, 1'b1, mfd_pkg::ST_PAYLOAD}},
    // A checksum of 253 or more can never match.
    '{mfd_pkg::START_BYTE, 1'b0, 1'b0, '0},
    '{8'hFD,               1'b0, 1'b0, '0},
    '{mfd_pkg::END_BYTE,   1'b1, 1'b1, '{8'd0, 1'b1, mfd_pkg::ST_CSUM_ERR}},
    // Plain mismatch: 10 + 20 is 30, not 31.
    '{mfd_pkg::START_BYTE, 1'b0, 1'b0, '0},
    '{8'h0A,               1'b0, 1'b0, '0},
    '{8'h14,               1'b0, 1'b0, '0},
    '{8'h1F,               1'b0, 1'b0, '0},
    '{mfd_pkg::END_BYTE,   1'b1, 1'b1, '{8'd0, 1'b1, mfd_pkg::ST_CSUM_ERR}},
    // The same frame with the right checksum, left to the model.
    '{mfd_pkg::START_BYTE, 1'b0, 1'b0, '0},
    '{8'h0A,               1'b0, 1'b0, '0},
    '{8'h14,               1'b0, 1'b0, '0},
    '{8'h1E,               1'b0, 1'b0, '0},
    '{mfd_pkg::END_BYTE,   1'b0, 1'b0, '0}
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       push       = 1'b0;
  logic [7:0] in_rx_byte = 8'd0;
  logic       pop        = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] out_status;

  // Model state: the frame hunter and body store as the block should hold them.
  logic        framing;
  logic [7:0]  body_mem [BODY_SLOTS];
  int unsigned body_len;
  int unsigned sum_before_latest;
  logic [7:0]  latest_body;

  mfd_pkg::res_t step_beats[$];    // beats caused by the byte just accepted
  mfd_pkg::res_t beats_due[$];     // beats still to be popped, oldest first
  mfd_pkg::res_t head_beat;

  int          error_count    = 0;
  int          frame_bytes    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_off_req   = 1'b0;
  int unsigned cycle_count    = 0;

  always #10 clk = ~clk;

  marker_frame_deframer_mod253_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_rx_byte (in_rx_byte),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status)
  );

  function automatic void restart_hunt();
    framing           = 1'b0;
    body_len          = 0;
    sum_before_latest = 0;
    latest_body       = 8'd0;
  endfunction

  // Advances the model by one received byte and leaves the beats that it
  // causes in step_beats.
  function automatic void deframe_byte(input logic [7:0] b);
    int unsigned i;
    step_beats.delete();
    if (!framing) begin
      if (b == mfd_pkg::START_BYTE) begin
        restart_hunt();
        framing = 1'b1;
      end
      return;
    end
    if (b != mfd_pkg::END_BYTE) begin
      if (body_len >= BODY_SLOTS) begin
        step_beats.push_back('{8'd0, 1'b1, mfd_pkg::ST_OVERFLOW});
        restart_hunt();
        return;
      end
      // The running sum always trails by one byte, since the newest body
      // byte may turn out to be the checksum.
      if (body_len > 0)
        sum_before_latest = (sum_before_latest + latest_body) % mfd_pkg::SUM_MOD;
      latest_body        = b;
      body_mem[body_len] = b;
      body_len++;
      return;
    end
    if (body_len == 0 || latest_body != sum_before_latest) begin
      step_beats.push_back('{8'd0, 1'b1, mfd_pkg::ST_CSUM_ERR});
    end else if (body_len == 1) begin
      step_beats.push_back('{8'd0, 1'b1, mfd_pkg::ST_EMPTY_OK});
    end else begin
      for (i = 0; i + 1 < body_len; i++)
        step_beats.push_back('{body_mem[i], (i + 2 == body_len), mfd_pkg::ST_PAYLOAD});
    end
    restart_hunt();
  endfunction

  // Offers one byte, idling first at the sender's current rate, and holds it
  // until it is taken. push stays high after the accepting edge so that
  // back-to-back bytes need no gap.
  task automatic push_byte(input logic [7:0] b, input bit use_model);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (full);
    deframe_byte(b);
    if (use_model)
      foreach (step_beats[k]) beats_due.push_back(step_beats[k]);
  endtask

  task automatic send_frame(input frame_kind_t kind, input int unsigned plen);
    int unsigned psum;
    int unsigned k;
    logic [7:0]  b;
    psum = 0;
    if (kind == FR_OVERFLOW)
      plen = BODY_SLOTS + 1;
    else if (kind == FR_NO_SUM)
      plen = 0;
    push_byte(mfd_pkg::START_BYTE, 1'b1);
    for (k = 0; k < plen; k++) begin
      // Any byte but the end marker; 255 is ordinary data here.
      b = 8'($urandom_range(0, 254));
      if (b == mfd_pkg::END_BYTE)
        b = mfd_pkg::START_BYTE;
      psum = (psum + b) % mfd_pkg::SUM_MOD;
      push_byte(b, 1'b1);
    end
    case (kind)
      FR_GOOD:     push_byte(8'(psum), 1'b1);
      FR_BAD_SUM:  push_byte(8'((psum + $urandom_range(1, 252)) % mfd_pkg::SUM_MOD), 1'b1);
      FR_HIGH_SUM: push_byte($urandom_range(0, 1) ? 8'hFD : 8'hFF, 1'b1);
      default: ;
    endcase
    // An overflowing frame is cut off by the block, so no end byte follows.
    if (kind != FR_OVERFLOW)
      push_byte(mfd_pkg::END_BYTE, 1'b1);
    frame_bytes += plen + ((kind == FR_OVERFLOW) ? 1 : (kind == FR_NO_SUM) ? 2 : 3);
  endtask

  task automatic send_random_frame();
    int unsigned roll;
    int unsigned plen;
    int unsigned n_noise;
    frame_kind_t kind;
    // Line noise between frames; the hunter must ignore it.
    if ($urandom_range(0, 99) < 15) begin
      n_noise = $urandom_range(1, 3);
      repeat (n_noise) push_byte(8'($urandom_range(0, 254)), 1'b1);
    end
    roll = $urandom_range(0, 99);
    if (roll < 62)      kind = FR_GOOD;
    else if (roll < 76) kind = FR_BAD_SUM;
    else if (roll < 84) kind = FR_HIGH_SUM;
    else if (roll < 94) kind = FR_NO_SUM;
    else if (roll < 96) kind = FR_OVERFLOW;
    else                kind = FR_GOOD;
    roll = $urandom_range(0, 99);
    if (roll < 70)      plen = $urandom_range(0, 6);
    else if (roll < 97) plen = $urandom_range(7, 20);
    else                plen = $urandom_range(BODY_SLOTS - 2, BODY_SLOTS - 1);
    send_frame(kind, plen);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    frame_bytes    = 0;
    while (frame_bytes < PHASE_BYTES)
      send_random_frame();
  endtask

  // Result side: pops at random at the current stall rate, and on request
  // holds off for a long stretch so that the body banks and queues fill and
  // full rises on the push side.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Every popped beat is matched against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got byte %0d last %0d status %0d",
                 $time, out_byte, out_last, out_status);
        error_count++;
      end else begin
        head_beat = beats_due.pop_front();
        if (out_byte !== head_beat.data) begin
          $display("%0t: out_byte expected %0d, got %0d", $time, head_beat.data, out_byte);
          error_count++;
        end
        if (out_last !== head_beat.last) begin
          $display("%0t: out_last expected %0d, got %0d", $time, head_beat.last, out_last);
          error_count++;
        end
        if (out_status !== head_beat.status) begin
          $display("%0t: out_status expected %0d, got %0d",
                   $time, head_beat.status, out_status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a lost beat or a stuck full flag ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t row;
    restart_hunt();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with both sides running flat out.
    for (int r = 0; r < N_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      push_byte(row.rx, !row.typed);
      if (row.typed && row.has_result)
        beats_due.push_back(row.want);
    end
    // A body one byte too long, then the longest frame that fits, which
    // drains the largest run of payload beats.
    send_frame(FR_OVERFLOW, 0);
    send_frame(FR_GOOD, BODY_SLOTS - 1);

    // Random traffic under each idling mix in turn.
    run_phase(0, 0);
    run_phase(69, 0);
    run_phase(0, 69);
    run_phase(20, 20);

    // Back-pressure: the result side stops while full-rate frames keep coming.
    // Each payload is longer than the result queue, so the first frame stalls
    // the drain and the second fills the other bank.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b1;
    repeat (3) send_frame(FR_GOOD, 8);

    push <= 1'b0;
    while (beats_due.size() != 0)
      @(posedge clk);
    // Allow for a stray beat that the model did not predict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
design/mfd_pkg.sv
design/mfd_ram.sv
design/mfd_fifo.sv
design/mfd_front.sv
design/mfd_back.sv
design/marker_frame_deframer_mod253_top.sv
test/tb_marker_frame_deframer_mod253_top.sv
